// ===== rtl/mf3_pkg.sv =====
// Package for the 3x3 median filter: field widths, register codes, reset values
// and the result type used by the top level.
// Depends on nothing.
package mf3_pkg;

    localparam int PIX_W          = 8;
    localparam int ROW_W          = 9;
    localparam int COL_OUT_W      = 9;
    localparam int CFG_W          = 10;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int HEIGHT_LIMIT   = 512;
    localparam int MIN_SIZE       = 3;
    localparam int WIDTH_RESET    = 512;
    localparam int HEIGHT_RESET   = 512;

    localparam int FIFO_DEPTH     = 3;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]     median;
        logic [ROW_W-1:0]     centre_row;
        logic [COL_OUT_W-1:0] centre_col;
        logic                 last;
    } t_result;

endpackage

// ===== rtl/mf3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the line stores; depends on nothing.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/mf3_median.sv =====
// Combinational median of nine values: column-wise sort of three, then the
// median of the maximum of minima, median of medians and minimum of maxima.
// Depends on nothing.
module mf3_median #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_win [9],
    output logic [W-1:0] o_median
);

    function automatic logic [W-1:0] min2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [W-1:0] max2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [W-1:0] med3(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [W-1:0] lo [3];
    logic [W-1:0] md [3];
    logic [W-1:0] hi [3];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            lo[g] = min2(min2(i_win[3*g], i_win[3*g+1]), i_win[3*g+2]);
            hi[g] = max2(max2(i_win[3*g], i_win[3*g+1]), i_win[3*g+2]);
            md[g] = med3(i_win[3*g], i_win[3*g+1], i_win[3*g+2]);
        end
        o_median = med3(max2(max2(lo[0], lo[1]), lo[2]),
                        med3(md[0], md[1], md[2]),
                        min2(min2(hi[0], hi[1]), hi[2]));
    end

endmodule

// ===== rtl/median_filter_3x3_top.sv =====
// Top level of the 3x3 median filter: counters, line stores, window and result queue.
// Depends on mf3_pkg, mf3_ram and mf3_median.
//
// Pixels enter in raster order, one beat per clock while o_in_stall is low. Accepting
// a beat registers it and reads both line stores at the pixel's column; from the
// registered beat the window shifts, the median is computed, the line stores are
// written back and the result is placed in the queue, offered once it is at the head.
// Only interior pixels produce a result beat. A three-entry result queue lets the
// input keep taking beats while results wait; the input stalls once the queued
// results plus the one being computed reach three.
// Sizes outside their range are saturated to [3, MAX_WIDTH] and [3, 512].
// The line stores need no clearing after reset.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_frame_start,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_median,
    output logic [ROW_W-1:0]      o_centre_row,
    output logic [COL_OUT_W-1:0]  o_centre_col,
    output logic                  o_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SB    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((MW_W > CFG_W) ? MW_W : CFG_W) + 1;
    localparam int QC_W  = $clog2(FIFO_DEPTH + 1);
    localparam int QI_W  = $clog2(FIFO_DEPTH);

    // Configuration registers
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    t_reg_idx         cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(WIDTH_RESET);
            r_image_height <= CFG_W'(HEIGHT_RESET);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // Position counters and the read stage
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [CMP_W-1:0] w_lim, h_lim, wv, hv, c_ext, r_ext, c_inc, r_inc;
    logic [CW-1:0]    c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             a_interior, a_last;
    logic             accept;

    logic             r_a_valid;
    logic [CW-1:0]    r_a_col;
    logic [ROW_W-1:0] r_a_row;
    logic [SB-1:0]    r_a_px;
    logic             r_a_interior;
    logic             r_a_last;

    logic             r_fwd;
    logic [SB-1:0]    r_fwd_top;
    logic [SB-1:0]    r_fwd_mid;

    logic [QC_W-1:0]  r_cnt;
    logic             push, pop;

    assign push       = r_a_valid && r_a_interior;
    assign pop        = (r_cnt != '0) && !i_out_stall;
    assign o_in_stall = ((CMP_W'(r_cnt) + CMP_W'(push)) >= CMP_W'(FIFO_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        wv = CMP_W'(r_image_width);
        hv = CMP_W'(r_image_height);
        if (wv < CMP_W'(MIN_SIZE)) begin
            w_lim = CMP_W'(MIN_SIZE);
        end else if (wv > CMP_W'(MAX_WIDTH)) begin
            w_lim = CMP_W'(MAX_WIDTH);
        end else begin
            w_lim = wv;
        end
        if (hv < CMP_W'(MIN_SIZE)) begin
            h_lim = CMP_W'(MIN_SIZE);
        end else if (hv > CMP_W'(HEIGHT_LIMIT)) begin
            h_lim = CMP_W'(HEIGHT_LIMIT);
        end else begin
            h_lim = hv;
        end

        c_cur = i_frame_start ? '0 : r_col;
        r_cur = i_frame_start ? '0 : r_row;
        if (CMP_W'(c_cur) >= w_lim) begin
            c_cur = '0;
        end
        if (CMP_W'(r_cur) >= h_lim) begin
            r_cur = '0;
        end
        c_ext = CMP_W'(c_cur);
        r_ext = CMP_W'(r_cur);

        c_inc = c_ext + CMP_W'(1);
        r_inc = r_ext + CMP_W'(1);
        if (c_inc >= w_lim) begin
            n_col = '0;
            n_row = (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[CW-1:0];
            n_row = r_cur;
        end

        a_interior = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2));
        a_last     = (r_ext == h_lim - CMP_W'(1)) && (c_ext == w_lim - CMP_W'(1));
    end

    // Line stores
    logic [SB-1:0] q_upper, q_middle;
    logic [SB-1:0] top, mid;

    assign top = r_fwd ? r_fwd_top : q_upper;
    assign mid = r_fwd ? r_fwd_mid : q_middle;

    mf3_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (mid),
        .i_re    (accept),
        .i_raddr (c_cur),
        .o_rdata (q_upper)
    );

    mf3_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (r_a_px),
        .i_re    (accept),
        .i_raddr (c_cur),
        .o_rdata (q_middle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_a_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_fwd <= r_a_valid && (r_a_col == c_cur);
            end
        end
    end

    // A read that meets the write of the previous beat at the same column
    // takes the data being written instead of the stale RAM word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_col      <= c_cur;
            r_a_row      <= r_cur;
            r_a_px       <= i_pixel[SB-1:0];
            r_a_interior <= a_interior;
            r_a_last     <= a_last;
            r_fwd_top    <= mid;
            r_fwd_mid    <= r_a_px;
        end
    end

    // Window and median
    logic [SB-1:0] r_win [6];
    logic [SB-1:0] win [9];
    logic [SB-1:0] med;
    t_result       res;

    always_comb begin
        win[0] = r_win[0];
        win[1] = r_win[3];
        win[2] = top;
        win[3] = r_win[1];
        win[4] = r_win[4];
        win[5] = mid;
        win[6] = r_win[2];
        win[7] = r_win[5];
        win[8] = r_a_px;
    end

    mf3_median #(
        .W (SB)
    ) u_median (
        .i_win    (win),
        .o_median (med)
    );

    always_comb begin
        res.median     = PIX_W'(med);
        res.centre_row = r_a_row - ROW_W'(1);
        res.centre_col = COL_OUT_W'(CMP_W'(r_a_col) - CMP_W'(1));
        res.last       = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_a_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_a_px;
        end
    end

    // Result queue; the head is always entry zero.
    t_result         r_q [FIFO_DEPTH];
    t_result         n_q [FIFO_DEPTH];
    logic [QC_W-1:0] n_cnt;
    logic [QC_W-1:0] wr_pos;

    always_comb begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        wr_pos = r_cnt - QC_W'(pop);
        if (push) begin
            n_q[wr_pos[QI_W-1:0]] = res;
        end
        n_cnt = r_cnt + QC_W'(push) - QC_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_median     = r_q[0].median;
    assign o_centre_row = r_q[0].centre_row;
    assign o_centre_col = r_q[0].centre_col;
    assign o_last       = r_q[0].last;

endmodule
